// File: sv/ccbe_pkg.sv
// Shared types, constants and fold functions for the byte-serial CRC engine.
package ccbe_pkg;

    localparam int unsigned CMD_QUEUE_DEPTH = 2;

    localparam logic [31:0] POLY32 = 32'hEDB8_8320;
    localparam logic [63:0] POLY64 = 64'hC96C_5795_D787_0F42;
    localparam logic [31:0] ONES32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {
        MODE_CRC32 = 1'b0,
        MODE_CRC64 = 1'b1
    } ccbe_mode_t;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        ccbe_mode_t  mode;
        logic        reload;
        logic        fold;
        logic        emit;
        logic [7:0]  data;
    } ccbe_cmd_t;

    function automatic logic [31:0] fold32(input logic [31:0] crc_in, input logic [7:0] byte_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (POLY32 ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [63:0] fold64(input logic [63:0] crc_in, input logic [7:0] byte_in);
        logic [63:0] c;
        c = crc_in ^ {56'd0, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (POLY64 ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/ccbe_front.sv
// Front end: holds the mode register, accepts input beats and classifies them.
module ccbe_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_wdata,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   has_byte,
    input  logic                   first_item,
    input  logic                   last_item,
    output logic                   cmd_valid,
    output ccbe_pkg::ccbe_cmd_t    cmd,
    input  logic                   cmd_ready,
    output ccbe_pkg::ccbe_mode_t   mode
);
    import ccbe_pkg::*;

    ccbe_mode_t mode_reg;
    logic       hold_valid_reg;
    logic       hold_valid_next;
    ccbe_cmd_t  cmd_reg;
    logic       accept;
    logic       front_ready;

    assign front_ready = !hold_valid_reg || cmd_ready;
    assign full        = !front_ready;
    assign accept      = push && front_ready;
    assign cmd_valid   = hold_valid_reg;
    assign cmd         = cmd_reg;
    assign mode        = mode_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_CRC32;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= ccbe_mode_t'(cfg_wdata);
            end
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Tag each beat with the mode in force when it arrives.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.mode   <= mode_reg;
            cmd_reg.reload <= first_item;
            cmd_reg.fold   <= has_byte;
            cmd_reg.emit   <= last_item;
            cmd_reg.data   <= data_byte;
        end
    end

endmodule

// File: sv/ccbe_cmd_fifo.sv
// Short command queue between the front end and the CRC back end.
module ccbe_cmd_fifo #(
    parameter int unsigned DEPTH = ccbe_pkg::CMD_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    input  ccbe_pkg::ccbe_cmd_t    wr_cmd,
    output logic                   rd_valid,
    input  logic                   rd_take,
    output ccbe_pkg::ccbe_cmd_t    rd_cmd
);
    import ccbe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ccbe_cmd_t         mem [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW-1:0]     rd_ptr_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;
    assign rd_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: sv/ccbe_back.sv
// Back end: running CRC register, byte fold network and result register.
module ccbe_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  ccbe_pkg::ccbe_cmd_t    cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  logic                   pop,
    output logic [63:0]            crc_value
);
    import ccbe_pkg::*;

    logic [63:0] running_crc_reg;
    logic [63:0] running_crc_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] crc_value_reg;
    logic [63:0] base_crc;
    logic [63:0] folded_crc;
    logic [63:0] final_crc;
    logic        slot_free;

    // Output slot frees up in the same cycle its beat is popped.
    assign slot_free = !out_valid_reg || pop;
    assign cmd_take  = cmd_valid && slot_free;
    assign empty     = !out_valid_reg;
    assign crc_value = crc_value_reg;

    always_comb
    begin
        base_crc = cmd.reload ? ONES64 : running_crc_reg;
        if (!cmd.fold)
        begin
            folded_crc = base_crc;
        end
        else if (cmd.mode == MODE_CRC64)
        begin
            folded_crc = fold64(base_crc, cmd.data);
        end
        else
        begin
            // CRC-32 folds the low word only and leaves the high word alone.
            folded_crc = {base_crc[63:32], fold32(base_crc[31:0], cmd.data)};
        end

        if (cmd.mode == MODE_CRC64)
        begin
            final_crc = ~folded_crc;
        end
        else
        begin
            final_crc = {32'd0, ~folded_crc[31:0]};
        end

        running_crc_next = running_crc_reg;
        out_valid_next   = out_valid_reg;
        if (cmd_take)
        begin
            running_crc_next = cmd.emit ? ONES64 : folded_crc;
        end
        if (cmd_take && cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= ONES64;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_crc_reg <= running_crc_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.emit)
        begin
            crc_value_reg <= final_crc;
        end
    end

endmodule

// File: sv/crc32_crc64_byte_engine_unit.sv
// Top level of the byte-serial CRC-32 / CRC-64/XZ engine.
// A result passes the front register, command queue and result register in turn.
// Throughput: one beat per cycle unless full; the 8-bit fold is combinational.
// The command queue absorbs short output stalls; full rises once queue and front fill.
// Reset: asynchronous, active low; mode returns to CRC-32, running CRC to all ones,
// and all queues empty.
module crc32_crc64_byte_engine_unit #(
    parameter int unsigned CMD_DEPTH = ccbe_pkg::CMD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        first_item,
    input  logic        last_item,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] crc_value
);
    import ccbe_pkg::*;

    logic       front_valid;
    ccbe_cmd_t  front_cmd;
    logic       queue_ready;
    logic       queue_valid;
    ccbe_cmd_t  queue_cmd;
    logic       back_take;
    ccbe_mode_t cur_mode;

    ccbe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .first_item (first_item),
        .last_item  (last_item),
        .cmd_valid  (front_valid),
        .cmd        (front_cmd),
        .cmd_ready  (queue_ready),
        .mode       (cur_mode)
    );

    ccbe_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (queue_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_take  (back_take),
        .rd_cmd   (queue_cmd)
    );

    ccbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_take  (back_take),
        .empty     (empty),
        .pop       (pop),
        .crc_value (crc_value)
    );

    // Back end never overwrites a result that has not been popped.
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (back_take && queue_cmd.emit) |-> (empty || pop))
        else $error("result overwritten before pop");

    // Back end only takes commands that are present.
    a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        back_take |-> queue_valid)
        else $error("command taken from empty queue");

    // CRC-32 results carry a zero upper word.
    a_crc32_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cur_mode == MODE_CRC32) |-> (crc_value[63:32] == 32'd0))
        else $error("CRC-32 result with nonzero upper word");

    // Full only while the front holds a beat that the queue cannot take.
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (front_valid && !queue_ready))
        else $error("full raised without a blocked front beat");

endmodule

// File: bench/crc_checker.sv
// Checker for the CRC engine: predicts each message CRC and compares every result beat.
`timescale 1ns / 1ps

module crc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        first_item,
    input  logic        last_item,
    input  logic        empty,
    input  logic        pop,
    input  logic [63:0] crc_value,
    input  logic        end_of_run,
    output int          mismatch_count,
    output int          crc_owed
);
    import ccbe_pkg::*;

    ccbe_mode_t  crc_mode_q;
    logic [63:0] running_crc;
    logic [63:0] crc_expected[$];
    logic        end_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] crc check: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Shift one byte through a reflected CRC register, LSB first.
    function automatic logic [63:0] shift_byte(input logic [63:0] crc, input logic [7:0] b,
                                               input ccbe_mode_t mode);
        logic [31:0] lo;
        logic [63:0] wide;
        if (mode == MODE_CRC64)
        begin
            wide = crc ^ {56'd0, b};
            for (int k = 0; k < 8; k++)
            begin
                wide = (wide >> 1) ^ (wide[0] ? POLY64 : 64'd0);
            end
            return wide;
        end
        // CRC-32 touches only the low word; keep the upper word as it is
        lo = crc[31:0] ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            lo = (lo >> 1) ^ (lo[0] ? POLY32 : 32'd0);
        end
        return {crc[63:32], lo};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        logic [63:0] next_crc;
        if (!rst_n)
        begin
            crc_mode_q     <= MODE_CRC32;
            running_crc    <= ONES64;
            crc_expected.delete();
            crc_owed       <= 0;
            mismatch_count = 0;
            end_seen       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                crc_mode_q <= ccbe_mode_t'(cfg_wdata);

            if (pop && !empty)
            begin
                if (crc_expected.size() == 0)
                    report_mismatch($sformatf("result beat 0x%016h with nothing expected",
                                              crc_value));
                else
                begin
                    want = crc_expected.pop_front();
                    if (crc_value !== want)
                        report_mismatch($sformatf("crc_value 0x%016h, expected 0x%016h",
                                                  crc_value, want));
                end
            end

            if (push && !full)
            begin
                next_crc = first_item ? ONES64 : running_crc;
                if (has_byte)
                    next_crc = shift_byte(next_crc, data_byte, crc_mode_q);
                if (last_item)
                begin
                    want = next_crc ^ ONES64;
                    if (crc_mode_q == MODE_CRC32)
                        want[63:32] = 32'd0;
                    crc_expected.push_back(want);
                    next_crc = ONES64;
                end
                running_crc <= next_crc;
            end

            crc_owed <= crc_expected.size();

            if (end_of_run && !end_seen)
            begin
                end_seen <= 1'b1;
                if (crc_expected.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              crc_expected.size()));
            end
        end
    end

endmodule

// File: bench/testbench.sv
// Top of the CRC engine bench: clock, reset, message stimulus, idling and the verdict.
`timescale 1ns / 1ps

module testbench;
    import ccbe_pkg::*;

    localparam int RANDOM_BEATS = 600;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first_item;
    logic        last_item;
    logic        empty;
    logic        pop;
    logic [63:0] crc_value;
    logic        end_of_run;
    int          mismatch_count;
    int          crc_owed;
    int          cycle_count = 0;
    int          beats_sent;
    logic        push_steady;

    crc32_crc64_byte_engine_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .has_byte   (has_byte),
        .first_item (first_item),
        .last_item  (last_item),
        .empty      (empty),
        .pop        (pop),
        .crc_value  (crc_value)
    );

    crc_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .first_item     (first_item),
        .last_item      (last_item),
        .empty          (empty),
        .pop            (pop),
        .crc_value      (crc_value),
        .end_of_run     (end_of_run),
        .mismatch_count (mismatch_count),
        .crc_owed       (crc_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one beat; called at a falling edge, returns at the falling edge after acceptance.
    task automatic send_beat(input logic [7:0] d, input logic h, input logic f, input logic l);
        int gap;
        gap = push_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        data_byte  = d;
        has_byte   = h;
        first_item = f;
        last_item  = l;
        push       = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // Drain, let the back end finish non-final beats, then write the mode.
    task automatic write_mode(input ccbe_mode_t m);
        push = 1'b0;
        while (crc_owed != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic send_check_string();
        for (int i = 0; i < 9; i++)
        begin
            send_beat(8'(8'h31 + i), 1'b1, i == 0, i == 8);
        end
    endtask

    // Well-formed message with random content; sometimes no first flag, sometimes an
    // empty closing beat.
    task automatic send_message(input int len);
        logic mark_first;
        logic empty_close;
        mark_first  = ($urandom_range(0, 5) != 0);
        empty_close = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
        begin
            send_beat(8'($urandom_range(0, 255)), 1'b1, mark_first && i == 0,
                      !empty_close && i == len - 1);
        end
        if (empty_close)
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
    endtask

    // Result side: draw a stall per beat, with calm stretches of no stall.
    initial
    begin
        int gap;
        int pops;
        logic pop_steady;
        pop        = 1'b0;
        pops       = 0;
        pop_steady = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (pops % 32 == 0)
                pop_steady = ($urandom_range(0, 2) == 0);
            gap = pop_steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                pop = 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            @(negedge clk);
            pops++;
        end
    end

    initial
    begin
        int next_switch;
        int kind;
        int len;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        push        = 1'b0;
        data_byte   = 8'h00;
        has_byte    = 1'b0;
        first_item  = 1'b0;
        last_item   = 1'b0;
        end_of_run  = 1'b0;
        beats_sent  = 0;
        push_steady = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, reset mode first
        send_beat(8'h00, 1'b0, 1'b1, 1'b1);          // empty message
        send_check_string();
        send_beat(8'h00, 1'b1, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1, 1'b1);
        send_beat(8'hA5, 1'b1, 1'b0, 1'b1);          // no first flag after a last
        send_beat(8'h5A, 1'b0, 1'b0, 1'b0);          // ignored beat
        send_beat(8'h3C, 1'b1, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b1, 1'b1, 1'b0);          // reload inside a message
        send_beat(8'h77, 1'b0, 1'b0, 1'b1);          // empty closing beat

        write_mode(MODE_CRC64);
        send_check_string();
        send_beat(8'h00, 1'b0, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1, 1'b1);
        send_beat(8'h12, 1'b1, 1'b1, 1'b0);
        // switch mode in the middle of a message
        write_mode(MODE_CRC32);
        send_beat(8'h34, 1'b1, 1'b0, 1'b1);
        send_beat(8'h56, 1'b1, 1'b1, 1'b0);
        write_mode(MODE_CRC64);
        send_beat(8'h78, 1'b1, 1'b0, 1'b1);

        // Random part
        beats_sent  = 0;
        next_switch = $urandom_range(60, 150);
        while (beats_sent < RANDOM_BEATS)
        begin
            if (beats_sent >= next_switch)
            begin
                write_mode(ccbe_mode_t'($urandom_range(0, 1)));
                next_switch = beats_sent + $urandom_range(60, 150);
            end
            push_steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                send_message(len);
            end
            else if (kind == 7)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
            else
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                end
            end
        end

        push = 1'b0;
        while (crc_owed != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        end_of_run = 1'b1;
        repeat (2) @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
sv/ccbe_pkg.sv
sv/ccbe_front.sv
sv/ccbe_cmd_fifo.sv
sv/ccbe_back.sv
sv/crc32_crc64_byte_engine_unit.sv
bench/crc_checker.sv
bench/testbench.sv
